// ===== hdl/phased_path_following_steering_defines.svh =====
// assertion macros for the steering block
// no dependencies
`ifndef PHASED_PATH_FOLLOWING_STEERING_DEFINES_SVH
`define PHASED_PATH_FOLLOWING_STEERING_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PPFS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define PPFS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== hdl/ppfs_pkg.sv =====
// shared types and constants for the steering block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ppfs_pkg;
  localparam int CordicSteps = 16;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] InvGainQ30 = 36'sd652032874;

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_ALIGN  = 3'd1;
  localparam logic [2:0] PH_CENTRE = 3'd2;
  localparam logic [2:0] PH_FOLLOW = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;

  localparam logic [2:0] REG_YAW_GAIN = 3'd0;
  localparam logic [2:0] REG_LAT_GAIN = 3'd1;
  localparam logic [2:0] REG_FWD_SPEED = 3'd2;
  localparam logic [2:0] REG_ALIGN_TICKS = 3'd3;
  localparam logic [2:0] REG_CENTRE_TICKS = 3'd4;
  localparam logic [2:0] REG_INNER = 3'd5;
  localparam logic [2:0] REG_OUTER = 3'd6;
  localparam logic [2:0] REG_BOOST = 3'd7;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    unique case (i)
      5'd0: r = 36'sd843314856;  5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043836;  5'd3: r = 36'sd133525158;
      5'd4: r = 36'sd67021686;   5'd5: r = 36'sd33543515;
      5'd6: r = 36'sd16775850;   5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194282;    5'd9: r = 36'sd2097149;
      5'd10: r = 36'sd1048575;   5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;    5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;     5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;     5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;       5'd23: r = 36'sd127;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

  // datapath commands from the controller
  typedef struct packed {
    logic load;        // capture word, start quaternion products
    logic prep;        // form atan2 terms
    logic vec_step;    // one vectoring step
    logic rot_init;    // round heading, start rotation
    logic rot_step;    // one rotation step
    logic fin_trig;    // round sin/cos
    logic mul_step;    // one output product step
    logic [4:0] step;  // cordic or product step number
    logic [2:0] phase; // phase for this tick
  } ppfs_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/ppfs_datapath.sv =====
// arithmetic of the steering block: cordic atan2, sin/cos, output products
// depends on ppfs_pkg
`timescale 1ns / 1ps
`default_nettype none
module ppfs_datapath
  import ppfs_pkg::*;
(
  input  wire logic clk,
  input  wire ppfs_cmd_t cmd,
  input  wire logic [15:0] in_angle,
  input  wire logic [15:0] in_err,
  input  wire logic [15:0] q_w,
  input  wire logic [15:0] q_x,
  input  wire logic [15:0] q_y,
  input  wire logic [15:0] q_z,
  input  wire logic [15:0] yaw_gain,
  input  wire logic [15:0] lat_gain,
  input  wire logic [15:0] fwd_speed,
  input  wire logic [13:0] inner_thr,
  input  wire logic [13:0] outer_thr,
  input  wire logic [13:0] boost,
  output logic signed [31:0] vx_o,
  output logic signed [31:0] vy_o,
  output logic signed [31:0] yr_o,
  output logic signed [15:0] head_o
);
  logic signed [15:0] ang_r, err_r;
  logic signed [32:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic signed [35:0] xv_r, yv_r, zv_r;
  logic               degen_r;
  logic signed [15:0] head_r;
  // cosine of a small angle rounds to +1.0, one bit above q1.15
  logic signed [16:0] sn_r, cs_r;
  logic signed [1:0]  quad_r;
  logic signed [17:0] eb_r;
  logic signed [63:0] a_r, b_r, t_r;
  logic signed [63:0] vx_r, vy_r, yr_r;

  logic signed [35:0] dx, dy, s_t, c_t, zsc, c1, s1;
  logic signed [35:0] rnd;
  logic [4:0] sh;
  logic signed [17:0] e_in, it, ot, bs, eb;
  always_comb begin
    sh = cmd.step;
    dx = yv_r >>> sh;
    dy = xv_r >>> sh;
    s_t = 36'(p_wz_r + p_xy_r) <<< 1;
    c_t = (36'sd1 <<< 30) - (36'(p_yy_r + p_zz_r) <<< 1);
    zsc = 36'(head_r) <<< 18;
    c1 = xv_r; s1 = yv_r;
    if (quad_r == 2'sd1) begin
      c1 = -yv_r; s1 = xv_r;
    end else if (quad_r == -2'sd1) begin
      c1 = yv_r; s1 = -xv_r;
    end
    rnd = zv_r + 36'sd131072;
    e_in = 18'(err_r);
    it = {4'd0, inner_thr}; ot = {4'd0, outer_thr}; bs = {4'd0, boost};
    eb = e_in;
    if (e_in > it) begin
      eb = (e_in > ot) ? e_in + bs + bs : e_in + bs;
    end else if (e_in < -it) begin
      eb = (e_in < -ot) ? e_in - bs - bs : e_in - bs;
    end
  end

  // output products: 17x17 signed multiply, one per step, chained over steps
  logic signed [33:0] m_p;
  logic signed [16:0] m_a, m_b;
  logic signed [63:0] lat_x, lat_y;
  logic [4:0] lsh;
  logic signed [63:0] yr_c, q48;
  logic signed [63:0] mag;
  logic [31:0] n16;
  logic [63:0] q3p;
  always_comb begin
    m_a = '0; m_b = '0;
    unique case (cmd.step)
      5'd0: begin m_a = 17'(ang_r); m_b = {1'b0, yaw_gain}; end
      // align works on the raw error, later phases on the boosted one
      5'd1: begin
        m_a = (cmd.phase == PH_ALIGN) ? 17'(err_r) : 17'(eb_r[16:0]); m_b = sn_r;
      end
      5'd2: begin
        m_a = (cmd.phase == PH_ALIGN) ? 17'(err_r) : 17'(eb_r[16:0]); m_b = -cs_r;
      end
      5'd3: begin m_a = cs_r; m_b = {1'b0, fwd_speed}; end
      5'd4: begin m_a = sn_r; m_b = {1'b0, fwd_speed}; end
      default: begin m_a = '0; m_b = '0; end
    endcase
    m_p = m_a * m_b;
    lsh = (cmd.phase == PH_ALIGN) ? 5'd22 : (cmd.phase == PH_CENTRE) ? 5'd20 : 5'd21;
    lat_x = (a_r + (64'sd1 <<< (lsh - 5'd1))) >>> lsh;
    lat_y = (b_r + (64'sd1 <<< (lsh - 5'd1))) >>> lsh;
    mag = (t_r < 0) ? -t_r : t_r;
    // divide by 48 as a shift by 4 then a reciprocal multiply by 1/3
    n16 = 32'((mag + 64'sd24) >>> 4);
    q3p = 64'(n16 * 32'hAAAAAAAB);
    q48 = 64'(q3p[63:33]);
    yr_c = (t_r < 0) ? -q48 : q48;
  end

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_r <= in_angle; err_r <= in_err;
      p_wz_r <= 33'(signed'(q_w) * signed'(q_z));
      p_xy_r <= 33'(signed'(q_x) * signed'(q_y));
      p_yy_r <= 33'(signed'(q_y) * signed'(q_y));
      p_zz_r <= 33'(signed'(q_z) * signed'(q_z));
      vx_r <= '0; vy_r <= '0; yr_r <= '0;
    end
    if (cmd.prep) begin
      degen_r <= (s_t == 0) && (c_t == 0);
      eb_r <= eb;
      if (c_t < 0) begin
        if (s_t >= 0) begin xv_r <= s_t; yv_r <= -c_t; zv_r <= HalfPiQ30; end
        else begin xv_r <= -s_t; yv_r <= c_t; zv_r <= -HalfPiQ30; end
      end else begin
        xv_r <= c_t; yv_r <= s_t; zv_r <= '0;
      end
    end
    if (cmd.vec_step) begin
      if (yv_r > 0) begin
        xv_r <= xv_r + dx; yv_r <= yv_r - dy; zv_r <= zv_r + atan_q30(sh);
      end else begin
        xv_r <= xv_r - dx; yv_r <= yv_r + dy; zv_r <= zv_r - atan_q30(sh);
      end
    end
    if (cmd.rot_init) begin
      head_r <= degen_r ? 16'sd0 : rnd[33:18];
    end
    if (cmd.fin_trig) begin
      cs_r <= 17'((c1 + 36'sd16384) >>> 15);
      sn_r <= 17'((s1 + 36'sd16384) >>> 15);
    end
    if (cmd.rot_step) begin
      if (sh == 5'd31) begin
        xv_r <= InvGainQ30; yv_r <= '0;
        if (zsc > HalfPiQ30) begin zv_r <= zsc - HalfPiQ30; quad_r <= 2'sd1; end
        else if (zsc < -HalfPiQ30) begin zv_r <= zsc + HalfPiQ30; quad_r <= -2'sd1; end
        else begin zv_r <= zsc; quad_r <= 2'sd0; end
      end else if (zv_r >= 0) begin
        xv_r <= xv_r - dx; yv_r <= yv_r + dy; zv_r <= zv_r - atan_q30(sh);
      end else begin
        xv_r <= xv_r + dx; yv_r <= yv_r - dy; zv_r <= zv_r + atan_q30(sh);
      end
    end
    if (cmd.mul_step) begin
      unique case (cmd.step)
        5'd0: t_r <= 64'(m_p);
        5'd1: a_r <= 64'(m_p);
        5'd2: b_r <= 64'(m_p);
        5'd5: begin
          // yaw scaling
          if (cmd.phase == PH_ALIGN) yr_r <= (t_r + 64'sd8) >>> 4;
          else if (cmd.phase == PH_CENTRE) yr_r <= yr_c;
          else yr_r <= (t_r + 64'sd4) >>> 3;
          t_r <= t_r * 5;
          a_r <= 64'($signed(a_r[33:0]) * $signed({1'b0, lat_gain}));
          b_r <= 64'($signed(b_r[33:0]) * $signed({1'b0, lat_gain}));
        end
        5'd6: begin
          if (cmd.phase == PH_CENTRE) yr_r <= yr_c;
          if (cmd.phase == PH_FOLLOW) begin
            a_r <= a_r * 5; b_r <= b_r * 5;
          end
        end
        5'd7: begin
          if (cmd.phase == PH_FOLLOW) begin
            vx_r <= lat_x + vx_r; vy_r <= lat_y + vy_r;
          end else begin
            vx_r <= lat_x; vy_r <= lat_y;
          end
        end
        5'd3: if (cmd.phase == PH_FOLLOW) vx_r <= (64'(m_p) + 64'sd64) >>> 7;
        5'd4: if (cmd.phase == PH_FOLLOW) vy_r <= (64'(m_p) + 64'sd64) >>> 7;
        default: ;
      endcase
    end
  end

  assign head_o = head_r;
  assign vx_o = sat(vx_r);
  assign vy_o = sat(vy_r);
  assign yr_o = sat(yr_r);
endmodule
`default_nettype wire

// ===== hdl/ppfs_ctrl.sv =====
// phase machine and sequencer of the steering block
// depends on ppfs_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "phased_path_following_steering_defines.svh"
module ppfs_ctrl
  import ppfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic in_det,
  input  wire logic out_fire,
  input  wire logic [9:0] align_ticks,
  input  wire logic [9:0] center_ticks,
  output logic busy,
  output logic out_valid,
  output ppfs_cmd_t cmd,
  output logic [2:0] phase_out
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_VEC = 3'd2,
                         S_HEAD = 3'd3, S_ROT = 3'd4, S_TRIG = 3'd5,
                         S_MUL = 3'd6, S_OUT = 3'd7;
  logic [2:0] st_r, st_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [2:0] phase_r, phase_nxt, tph_r, tph_nxt;
  logic [9:0] tick_r, tick_nxt;
  logic [2:0] ph;
  logic [10:0] tc;
  logic active;

  always_comb begin
    ph = (phase_r > PH_HOLD) ? PH_HOLD : phase_r;
    phase_nxt = phase_r; tick_nxt = tick_r; tph_nxt = tph_r;
    st_nxt = st_r; cnt_nxt = cnt_r;
    cmd = '0; cmd.phase = tph_r; cmd.step = cnt_r;
    active = (tph_r == PH_ALIGN) || (tph_r == PH_CENTRE) || (tph_r == PH_FOLLOW);
    tc = {1'b0, tick_r} + 11'd1;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        if (ph == PH_WAIT && in_det) begin
          tph_nxt = PH_ALIGN; tick_nxt = '0;
        end else if (ph != PH_WAIT && ph != PH_HOLD && !in_det) tph_nxt = PH_HOLD;
        else tph_nxt = ph;
        phase_nxt = tph_nxt;
        st_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1; cnt_nxt = '0; st_nxt = S_VEC;
      end
      S_VEC: begin
        cmd.vec_step = 1'b1; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicSteps - 1)) st_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.rot_init = 1'b1; cnt_nxt = 5'd31;
        st_nxt = active ? S_ROT : S_OUT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicSteps - 1)) st_nxt = S_TRIG;
      end
      S_TRIG: begin
        cmd.fin_trig = 1'b1; cnt_nxt = '0; st_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd7) begin
          st_nxt = S_OUT;
          if (tph_r == PH_ALIGN || tph_r == PH_CENTRE) begin
            if (tc >= {1'b0, (tph_r == PH_ALIGN) ? align_ticks : center_ticks}) begin
              phase_nxt = tph_r + 3'd1; tick_nxt = '0;
            end else tick_nxt = tc[9:0];
          end
        end
      end
      S_OUT: if (out_fire) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; phase_r <= PH_WAIT; tick_r <= '0; tph_r <= PH_WAIT;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; phase_r <= phase_nxt;
      tick_r <= tick_nxt; tph_r <= tph_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign phase_out = tph_r;

  `PPFS_ASSERT_IMP(a_no_accept_busy, in_fire, st_r == S_IDLE, "word accepted while busy")
  `PPFS_ASSERT_NXT(a_hold_sticks, st_r == S_IDLE && phase_r == PH_HOLD,
    phase_r == PH_HOLD, "hold phase left")
  `PPFS_ASSERT_IMP(a_out_in_out, out_fire, st_r == S_OUT, "result without out state")
endmodule
`default_nettype wire

// ===== hdl/phased_path_following_steering.sv =====
// phased path-following steering controller, top level
// depends on ppfs_pkg, ppfs_ctrl and ppfs_datapath
//
// usage
// - in_ channel takes one word per control tick: detect flag in in_tuser,
//   angle, error and quaternion in in_tdata
// - out_ channel returns one word per tick: three velocities, phase, heading
// - after acceptance when active, out_tvalid rises once the prep, vectoring,
//   heading round, rotation, trig and product steps are done; in wait or
//   hold only prep, vectoring and heading round run before it
// - one word in flight; in_tready is low from acceptance until the result
//   is taken, so a stalled receiver holds the block
// - reset (rst_n low, synchronous) restores register defaults, wait phase
// - cfg writes take effect at the next tick; write only while idle
// - outputs saturate to the signed 32 bit range
//
`timescale 1ns / 1ps
`default_nettype none
module phased_path_following_steering
  import ppfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // rel_angle, center_error, quat_w, quat_x, quat_y, quat_z
  input  wire logic [95:0] in_tdata,
  // detect_ok
  input  wire logic in_tuser,
  output logic out_tvalid,
  input  wire logic out_tready,
  // vel_east, vel_north, yaw_rate, phase_now, heading_out, zero pad
  output logic [119:0] out_tdata,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0] yaw_gain_r, lat_gain_r, fwd_r;
  logic [9:0]  align_r, centre_r;
  logic [13:0] inner_r, outer_r, boost_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_gain_r <= 16'd38400; lat_gain_r <= 16'd77; fwd_r <= 16'd256;
      align_r <= 10'd200; centre_r <= 10'd600;
      inner_r <= 14'd492; outer_r <= 14'd1311; boost_r <= 14'd1147;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_GAIN:     yaw_gain_r <= cfg_wdata;
        REG_LAT_GAIN:     lat_gain_r <= cfg_wdata;
        REG_FWD_SPEED:    fwd_r <= cfg_wdata;
        REG_ALIGN_TICKS:  align_r <= cfg_wdata[9:0];
        REG_CENTRE_TICKS: centre_r <= cfg_wdata[9:0];
        REG_INNER:        inner_r <= cfg_wdata[13:0];
        REG_OUTER:        outer_r <= cfg_wdata[13:0];
        REG_BOOST:        boost_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  logic busy, in_fire, out_fire;
  ppfs_cmd_t cmd;
  logic [2:0] phase;
  logic signed [31:0] vx, vy, yr;
  logic signed [15:0] head;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  ppfs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_det(in_tuser), .out_fire,
    .align_ticks(align_r), .center_ticks(centre_r),
    .busy, .out_valid(out_tvalid), .cmd, .phase_out(phase)
  );

  ppfs_datapath u_dp (
    .clk, .cmd,
    .in_angle(in_tdata[15:0]), .in_err(in_tdata[31:16]),
    .q_w(in_tdata[47:32]), .q_x(in_tdata[63:48]),
    .q_y(in_tdata[79:64]), .q_z(in_tdata[95:80]),
    .yaw_gain(yaw_gain_r), .lat_gain(lat_gain_r), .fwd_speed(fwd_r),
    .inner_thr(inner_r), .outer_thr(outer_r), .boost(boost_r),
    .vx_o(vx), .vy_o(vy), .yr_o(yr), .head_o(head)
  );

  // idle phases give zero motion
  logic idle_ph;
  assign idle_ph = (phase == PH_WAIT) || (phase == PH_HOLD);
  assign out_tdata = {5'd0, head, phase,
                      idle_ph ? 32'd0 : yr, idle_ph ? 32'd0 : vy, idle_ph ? 32'd0 : vx};
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// self-checking bench for the phased path-following steering block
// drives ticks and register writes, predicts every result word and compares it
// depends on ppfs_pkg and phased_path_following_steering
`timescale 1ns / 1ps

// scoreboard: steering predictor with its own state, plus the queue of results to come
class steer_board;
  logic [15:0] yaw_gain, lat_gain, fwd_speed;
  logic [9:0] align_ticks, centre_ticks;
  logic [13:0] inner_thr, outer_thr, boost;
  logic [2:0] phase;
  logic [9:0] ticks;
  logic [119:0] pending_words[$];
  int mismatches;
  longint atan_q30[24];

  function new();
    atan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    yaw_gain = 38400; lat_gain = 77; fwd_speed = 256;
    align_ticks = 200; centre_ticks = 600;
    inner_thr = 492; outer_thr = 1311; boost = 1147;
    phase = ppfs_pkg::PH_WAIT; ticks = 0; mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      ppfs_pkg::REG_YAW_GAIN: yaw_gain = val;
      ppfs_pkg::REG_LAT_GAIN: lat_gain = val;
      ppfs_pkg::REG_FWD_SPEED: fwd_speed = val;
      ppfs_pkg::REG_ALIGN_TICKS: align_ticks = val[9:0];
      ppfs_pkg::REG_CENTRE_TICKS: centre_ticks = val[9:0];
      ppfs_pkg::REG_INNER: inner_thr = val[13:0];
      ppfs_pkg::REG_OUTER: outer_thr = val[13:0];
      default: boost = val[13:0];
    endcase
  endfunction

  // arithmetic shift with rounding offset already added by the caller
  function longint sra(longint v, int sh);
    return v >>> sh;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint yaw_angle(longint w, longint x, longint y, longint z);
    longint s, c, xv, yv, ang, dx, dy;
    s = 2 * (w * z + x * y);
    c = (64'sd1 <<< 30) - 2 * (y * y + z * z);
    if (s == 0 && c == 0) return 0;
    if (c < 0) begin
      if (s >= 0) begin
        xv = s; yv = -c; ang = 1686629713;
      end else begin
        xv = -s; yv = c; ang = -1686629713;
      end
    end else begin
      xv = c; yv = s; ang = 0;
    end
    for (int i = 0; i < 16; i++) begin
      dx = sra(yv, i); dy = sra(xv, i);
      if (yv > 0) begin
        xv += dx; yv -= dy; ang += atan_q30[i];
      end else begin
        xv -= dx; yv += dy; ang -= atan_q30[i];
      end
    end
    return sra(ang + (64'sd1 <<< 17), 18);
  endfunction

  function void trig_of(longint th, output longint sn, output longint cs);
    longint z, xv, yv, dx, dy, t;
    int quad;
    z = th * 262144; xv = 652032874; yv = 0; quad = 0;
    if (z > 1686629713) begin
      z -= 1686629713; quad = 1;
    end else if (z < -1686629713) begin
      z += 1686629713; quad = -1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = sra(yv, i); dy = sra(xv, i);
      if (z >= 0) begin
        xv -= dx; yv += dy; z -= atan_q30[i];
      end else begin
        xv += dx; yv -= dy; z += atan_q30[i];
      end
    end
    if (quad == 1) begin
      t = xv; xv = -yv; yv = t;
    end else if (quad == -1) begin
      t = xv; xv = yv; yv = -t;
    end
    cs = sra(xv + (1 << 14), 15);
    sn = sra(yv + (1 << 14), 15);
  endfunction

  function longint lat_term(longint e, longint trig, longint num, int sh);
    return sra(e * trig * longint'(lat_gain) * num + (64'sd1 <<< (sh - 1)), sh);
  endfunction

  function longint boosted(longint e);
    if (e > longint'(inner_thr)) begin
      if (e > longint'(outer_thr)) e += boost;
      e += boost;
    end else if (e < -longint'(inner_thr)) begin
      if (e < -longint'(outer_thr)) e -= boost;
      e -= boost;
    end
    return e;
  endfunction

  function void count_tick(logic [9:0] lim, logic [2:0] nxt);
    int tc;
    tc = ticks + 1;
    if (tc >= lim) begin
      phase = nxt; ticks = 0;
    end else ticks = tc[9:0];
  endfunction

  // note an accepted tick: work out the result word it must produce
  function void note_tick(logic det, logic [95:0] d);
    longint ang, err, head, sn, cs, vx, vy, yr, p, q, e;
    logic [2:0] ph;
    logic [31:0] vx32, vy32, yr32;
    ang = $signed(d[15:0]); err = $signed(d[31:16]);
    head = yaw_angle($signed(d[47:32]), $signed(d[63:48]), $signed(d[79:64]),
                     $signed(d[95:80]));
    vx = 0; vy = 0; yr = 0; sn = 0; cs = 0;
    ph = (phase > ppfs_pkg::PH_HOLD) ? ppfs_pkg::PH_HOLD : phase;
    if (ph == ppfs_pkg::PH_WAIT && det) begin
      ph = ppfs_pkg::PH_ALIGN; ticks = 0;
    end else if (ph >= ppfs_pkg::PH_ALIGN && ph <= ppfs_pkg::PH_FOLLOW && !det)
      ph = ppfs_pkg::PH_HOLD;
    phase = ph;
    if (ph >= ppfs_pkg::PH_ALIGN && ph <= ppfs_pkg::PH_FOLLOW) trig_of(head, sn, cs);
    if (ph == ppfs_pkg::PH_ALIGN) begin
      yr = sra(longint'(yaw_gain) * ang + 8, 4);
      vx = lat_term(err, sn, 1, 22);
      vy = lat_term(err, -cs, 1, 22);
      count_tick(align_ticks, ppfs_pkg::PH_CENTRE);
    end else if (ph == ppfs_pkg::PH_CENTRE) begin
      p = longint'(yaw_gain) * ang * 5;
      q = ((p < 0 ? -p : p) + 24) / 48;
      yr = p < 0 ? -q : q;
      e = boosted(err);
      vx = lat_term(e, sn, 1, 20);
      vy = lat_term(e, -cs, 1, 20);
      count_tick(centre_ticks, ppfs_pkg::PH_FOLLOW);
    end else if (ph == ppfs_pkg::PH_FOLLOW) begin
      e = boosted(err);
      yr = sra(longint'(yaw_gain) * ang + 4, 3);
      vx = lat_term(e, sn, 5, 21) + sra(longint'(fwd_speed) * cs + 64, 7);
      vy = lat_term(e, -cs, 5, 21) + sra(longint'(fwd_speed) * sn + 64, 7);
    end
    vx32 = 32'(clamp32(vx)); vy32 = 32'(clamp32(vy)); yr32 = 32'(clamp32(yr));
    pending_words.push_back({5'd0, head[15:0], ph, yr32, vy32, vx32});
  endfunction

  function void check_word(logic [119:0] got);
    logic [119:0] want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result word with nothing expected: %h", got);
      return;
    end
    want = pending_words.pop_front();
    if (got[31:0] !== want[31:0] || got[63:32] !== want[63:32] ||
        got[95:64] !== want[95:64] || got[98:96] !== want[98:96] ||
        got[114:99] !== want[114:99] || got[119:115] !== want[119:115]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: vel_e %h/%h vel_n %h/%h yaw %h/%h phase %0d/%0d head %h/%h",
                 want[31:0], got[31:0], want[63:32], got[63:32], want[95:64],
                 got[95:64], want[98:96], got[98:96], want[114:99], got[114:99]);
    end
  endfunction
endclass

module tb;
  import ppfs_pkg::*;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [95:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [119:0] out_tdata;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;

  steer_board board;
  // idle rates in percent for each side, changed per phase of the run
  int send_idle, recv_idle;
  // long hold-off on the receiver, counted in its own process
  int recv_hold;
  int idle_cycles;

  phased_path_following_steering dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, checks every word it takes
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else begin
      if (out_tvalid && out_tready) board.check_word(out_tdata);
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_tready <= 0;
      end else out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // offer one tick and hold it until taken; random gap first
  task automatic send_tick(logic det, logic [95:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tuser <= det; in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(det, d);
  endtask

  // stop offering, wait until all results are in, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // quaternion near unit length, or raw noise now and then
  function automatic logic [63:0] quat_word();
    logic [63:0] q;
    q = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      q[15:0] = 16'($urandom_range(32767));
      q[15:0] = $urandom_range(1) ? q[15:0] : -q[15:0];
      q[63:48] = $signed(q[63:48]) >>> 1; q[47:16] = $signed(q[47:16]) >>> 3;
    end
    return q;
  endfunction

  task automatic random_ticks(int n, int loss_pct);
    logic [95:0] d;
    for (int i = 0; i < n; i++) begin
      d = {quat_word(), ($urandom_range(3) == 0) ? edge_val() : 16'($urandom_range(4000)) - 16'd2000,
           ($urandom_range(4) == 0) ? edge_val() : 16'($urandom)};
      send_tick($urandom_range(99) >= loss_pct, d);
    end
  endtask

  // restart the phase machine is impossible without reset, so each pass
  // uses short tick counts to reach every phase before hold latches
  initial begin
    board = new();
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    cfg_we = 0; cfg_index = REG_YAW_GAIN; cfg_wdata = '0;
    send_idle = 11; recv_idle = 66; recv_hold = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // short phases so align, centre and follow all get visited
    reg_write(REG_ALIGN_TICKS, 3);
    reg_write(REG_CENTRE_TICKS, 0);
    reg_write(REG_INNER, 492);
    reg_write(REG_OUTER, 100);
    reg_write(REG_BOOST, 16383);

    // directed: wait ticks, then extremes through each phase
    send_tick(0, '0);
    send_tick(0, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_tick(1, {16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff}); // zero quat
    send_tick(1, {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_tick(1, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_tick(1, {16'h0, 16'h0, 16'h0, 16'h7fff, 16'd600, 16'd4096}); // centre
    send_tick(1, {16'h4000, 16'h0, 16'h0, 16'h5a82, -16'sd600, -16'sd4096}); // follow
    send_tick(1, {16'h0, 16'h0, 16'h0, 16'h7fff, 16'd50, 16'd1});
    send_tick(1, {16'h0, 16'h7fff, 16'h0, 16'h0, 16'h7fff, 16'h8000});
    send_tick(1, {16'h0, 16'h0, 16'h7fff, 16'h0, 16'h8000, 16'h7fff});
    send_tick(1, {16'h8000, 16'h0, 16'h0, 16'h8000, 16'h8000, 16'h8000});
    send_tick(0, {16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h7fff, 16'h7fff}); // lost
    send_tick(1, {16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h7fff, 16'h7fff}); // hold stays
    drain();

    // hold latched; registers still exercised at extremes, outputs stay idle
    reg_write(REG_YAW_GAIN, 16'hffff);
    reg_write(REG_LAT_GAIN, 16'hffff);
    reg_write(REG_FWD_SPEED, 16'hffff);
    reg_write(REG_ALIGN_TICKS, 1023);
    reg_write(REG_CENTRE_TICKS, 1);
    reg_write(REG_INNER, 0);
    reg_write(REG_OUTER, 16383);
    reg_write(REG_BOOST, 0);
    random_ticks(60, 50);

    // long receiver hold-off while the sender keeps offering
    @(posedge clk);
    recv_hold <= 400;
    random_ticks(10, 50);
    drain();

    send_idle = 66; recv_idle = 11;
    random_ticks(220, 50);
    drain();
    reg_write(REG_YAW_GAIN, 0);
    reg_write(REG_LAT_GAIN, 0);
    reg_write(REG_FWD_SPEED, 0);
    send_idle = 0; recv_idle = 0;
    random_ticks(300, 50);
    drain();

    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== phased_path_following_steering.f =====
+incdir+hdl
hdl/ppfs_pkg.sv
hdl/ppfs_datapath.sv
hdl/ppfs_ctrl.sv
hdl/phased_path_following_steering.sv
verif/tb.sv
